@@ rtl/pcrc_pkg.sv @@
// Package for the parameterized CRC engine: config types, reset values and bit helpers.
package pcrc_pkg;

  // Register map indexes (byte address is 4 * index)
  localparam int unsigned RegCount = 6;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned IdxW     = 3;

  typedef enum logic [IdxW-1:0] {
    REG_WIDTH   = 3'd0,
    REG_POLY    = 3'd1,
    REG_INIT    = 3'd2,
    REG_REFIN   = 3'd3,
    REG_REFOUT  = 3'd4,
    REG_XOROUT  = 3'd5
  } pcrc_reg_e;

  localparam logic [5:0]  WidthMin     = 6'd8;
  localparam logic [5:0]  WidthMax     = 6'd32;
  localparam logic [5:0]  WidthRst     = 6'd32;
  localparam logic [31:0] PolyRst      = 32'h04C1_1DB7;
  localparam logic [31:0] InitRst      = 32'hFFFF_FFFF;
  localparam logic        RefinRst     = 1'b1;
  localparam logic        RefoutRst    = 1'b1;
  localparam logic [31:0] XoroutRst    = 32'hFFFF_FFFF;

  // Live configuration handed from the register block to the datapath
  typedef struct packed {
    logic [5:0]  width;
    logic [31:0] poly;
    logic [31:0] init;
    logic        refin;
    logic        refout;
    logic [31:0] xorout;
  } pcrc_cfg_t;

  // Pipeline status seen by the top level
  typedef struct packed {
    logic stage_valid;
    logic stage_last;
    logic in_msg;
  } pcrc_stat_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // Left shift needed to put a width-bit value at the top of 32 bits
  function automatic logic [5:0] align_shift(input logic [5:0] w);
    return WidthMax - w;
  endfunction

  function automatic logic [31:0] width_mask(input logic [5:0] w);
    return 32'hFFFF_FFFF >> align_shift(w);
  endfunction

  // Eight MSB-first polynomial steps on a top-aligned register
  function automatic logic [31:0] step8(input logic [31:0] r_in, input logic [31:0] poly_al);
    logic [31:0] r;
    r = r_in;
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ((r << 1) ^ poly_al) : (r << 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/pcrc_in_if.sv @@
// Input channel: one message byte per beat.
interface pcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/pcrc_out_if.sv @@
// Output channel: one finished CRC per beat.
interface pcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_result;

  modport source (output valid, output crc_result, input ready);
  modport sink (input valid, input crc_result, output ready);
endinterface

@@ rtl/pcrc_cfg.sv @@
// APB-style configuration registers of the CRC engine.
module pcrc_cfg
  import pcrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pcrc_cfg_t          cfg_o
);

  pcrc_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  logic [IdxW-1:0] idx;
  logic [5:0] w_in;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[AddrW-1:2];
  assign w_in   = pwdata[5:0];

  // Write decode with width saturation
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH: begin
          if (w_in < WidthMin) cfg_d.width = WidthMin;
          else if (w_in > WidthMax) cfg_d.width = WidthMax;
          else cfg_d.width = w_in;
        end
        REG_POLY:   cfg_d.poly   = pwdata;
        REG_INIT:   cfg_d.init   = pwdata;
        REG_REFIN:  cfg_d.refin  = pwdata[0];
        REG_REFOUT: cfg_d.refout = pwdata[0];
        REG_XOROUT: cfg_d.xorout = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WidthRst;
      cfg_q.poly   <= PolyRst;
      cfg_q.init   <= InitRst;
      cfg_q.refin  <= RefinRst;
      cfg_q.refout <= RefoutRst;
      cfg_q.xorout <= XoroutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WIDTH:  prdata = {26'd0, cfg_q.width};
      REG_POLY:   prdata = cfg_q.poly;
      REG_INIT:   prdata = cfg_q.init;
      REG_REFIN:  prdata = {31'd0, cfg_q.refin};
      REG_REFOUT: prdata = {31'd0, cfg_q.refout};
      REG_XOROUT: prdata = cfg_q.xorout;
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pcrc_core.sv @@
// CRC datapath: input byte register, one-byte update, result register.
module pcrc_core
  import pcrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pcrc_cfg_t   cfg_i,
  pcrc_in_if.sink     in_i,
  pcrc_out_if.source  out_o,
  output pcrc_stat_t  stat_o
);

  logic        stg_vld_q, stg_vld_d;
  logic [7:0]  stg_byte_q;
  logic        stg_last_q;
  logic [31:0] crc_q, crc_d;
  logic        in_msg_q, in_msg_d;
  logic        out_vld_q, out_vld_d;
  logic [31:0] res_q;

  logic        adv, accept;
  logic [5:0]  sh;
  logic [31:0] start, aligned, poly_al, folded, next_al, refl, res;
  logic [7:0]  b;

  // Stage moves on unless a last byte would overwrite a waiting result
  assign adv    = stg_vld_q && (!stg_last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !stg_vld_q || adv;
  assign accept = in_i.valid && in_i.ready;

  // One byte through the register, kept top-aligned so any width shares the net
  assign sh      = align_shift(cfg_i.width);
  assign start   = in_msg_q ? crc_q : cfg_i.init;
  assign aligned = start << sh;
  assign poly_al = cfg_i.poly << sh;
  assign b       = cfg_i.refin ? rev8(stg_byte_q) : stg_byte_q;
  assign folded  = aligned ^ {b, 24'd0};
  assign next_al = step8(folded, poly_al);
  // reversing the top-aligned word reverses the low width bits in place
  assign refl    = cfg_i.refout ? rev32(next_al) : (next_al >> sh);
  assign res     = (refl ^ cfg_i.xorout) & width_mask(cfg_i.width);

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (accept) stg_vld_d = 1'b1;
    else if (adv) stg_vld_d = 1'b0;
  end

  assign crc_d    = adv ? (next_al >> sh) : crc_q;
  assign in_msg_d = adv ? !stg_last_q : in_msg_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv && stg_last_q) out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      in_msg_q  <= 1'b0;
      out_vld_q <= 1'b0;
      crc_q     <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      in_msg_q  <= in_msg_d;
      out_vld_q <= out_vld_d;
      crc_q     <= crc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_byte_q <= in_i.data_byte;
      stg_last_q <= in_i.last_byte;
    end
    if (adv && stg_last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.crc_result = res_q;

  assign stat_o.stage_valid = stg_vld_q;
  assign stat_o.stage_last  = stg_last_q;
  assign stat_o.in_msg      = in_msg_q;

endmodule

@@ rtl/parameterized_crc_engine.sv @@
// Top level of the parameterized CRC engine (width 8..32, Rocksoft model).
// Flow: a byte is registered on acceptance and folded in as it leaves the stage; the CRC
//   of a message is registered in the result register when its last byte leaves the stage.
// Throughput: one byte per cycle, set by the combinational 8-step XOR network; a last
//   byte waits in the stage only while the previous result is held by the receiver.
// Reset: async active low; config returns to CRC-32, no message open, no beats held.
module parameterized_crc_engine
  import pcrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pcrc_in_if.sink            in_i,
  pcrc_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  pcrc_cfg_t  cfg;
  pcrc_stat_t stat;

  pcrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcrc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o),
    .stat_o (stat)
  );

  // Input stalls only while a byte sits in the stage
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> stat.stage_valid)
    else $error("input stalled with empty stage");

  // A new result comes only from a last byte leaving the stage
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(stat.stage_valid && stat.stage_last))
    else $error("result without a last byte");

  // A last byte blocked by a waiting result stays in the stage
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stage_valid && stat.stage_last && out_o.valid && !out_o.ready
      |=> stat.stage_valid && stat.stage_last)
    else $error("last byte lost under back-pressure");

  // No result bits above the configured width
  a_result_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.crc_result & ~width_mask(cfg.width)) == 32'd0))
    else $error("result bits above width");

endmodule
